### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk_i with rst_ni as the disable condition
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define ASSERT_ON(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_ON(name, prop, msg)
`define ASSERT_NEVER(name, cond, msg)
`endif

`endif

### src/tdds_pkg.sv
// ---------------------------------------------------------------------------
// tdds_pkg
// shared types and constants of the thruster direction detect sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package tdds_pkg;

  localparam int unsigned MOTOR_COUNT = 8;
  // slots in the enable mask and factor table
  localparam int unsigned MOTOR_SLOTS = 8;
  localparam int unsigned SLOT_W      = $clog2(MOTOR_SLOTS);
  localparam int unsigned MOTOR_W     = 4;
  localparam int unsigned MOTOR_LIMIT = (MOTOR_COUNT < MOTOR_SLOTS) ? MOTOR_COUNT : MOTOR_SLOTS;
  localparam logic [MOTOR_W-1:0] MOTOR_END = MOTOR_W'(MOTOR_LIMIT);

  localparam logic [10:0] NEUTRAL_PWM = 11'd1500;
  localparam logic [8:0]  MAX_OFFSET  = 9'd500;

  // sign codes, same encoding as the factor table
  localparam logic [1:0] SGN_ZERO  = 2'd0;
  localparam logic [1:0] SGN_PLUS  = 2'd1;
  localparam logic [1:0] SGN_NEVER = 2'd2;
  localparam logic [1:0] SGN_MINUS = 2'd3;

  typedef enum logic [2:0] {
    CFG_ENABLED_MASK    = 3'd0,
    CFG_FACTOR_TABLE    = 3'd1,
    CFG_TILT_THRESHOLD  = 3'd2,
    CFG_YAW_THRESHOLD   = 3'd3,
    CFG_STILL_THRESHOLD = 3'd4,
    CFG_SETTLE_TIME     = 3'd5,
    CFG_PULSE_TIME      = 3'd6,
    CFG_PULSE_OFFSET    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_STANDBY   = 3'd0,
    PH_SETTLING  = 3'd1,
    PH_THRUSTING = 3'd2,
    PH_DETECTING = 3'd3,
    PH_DONE      = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OK       = 3'd1,
    EV_REVERSED = 3'd2,
    EV_RETRY    = 3'd3,
    EV_FAILED   = 3'd4,
    EV_COMPLETE = 3'd5
  } event_e;

  typedef struct packed {
    logic [7:0]  enabled_mask;
    logic [47:0] factor_table;
    logic [14:0] tilt_threshold;
    logic [14:0] yaw_threshold;
    logic [31:0] still_threshold;
    logic [15:0] settle_time;
    logic [15:0] pulse_time;
    logic [8:0]  pulse_offset;
  } cfg_t;

  typedef struct packed {
    logic               armed;
    logic [31:0]        now_ms;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               pulse_accepted;
  } in_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        drive_all_neutral;
    logic        drive_one;
    logic [3:0]  drive_motor;
    logic [10:0] pwm_command;
    logic [2:0]  event_res;
    logic [3:0]  event_motor;
    logic        finish_request;
  } out_t;

  // tick after squaring and axis classification
  typedef struct packed {
    logic        armed;
    logic [31:0] now_ms;
    logic        pulse_accepted;
    logic [31:0] sq_sum;
    logic [1:0]  sgn_x;
    logic [1:0]  sgn_y;
    logic [1:0]  sgn_z;
  } pre_t;

  function automatic logic [1:0] sgn_neg(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      SGN_PLUS:  r = SGN_MINUS;
      SGN_MINUS: r = SGN_PLUS;
      default:   r = s;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tdds_cfg.sv
// ---------------------------------------------------------------------------
// tdds_cfg
// configuration register file, one register written per beat
// ---------------------------------------------------------------------------
`default_nettype none

module tdds_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [47:0]   cfg_data_i,
  output tdds_pkg::cfg_t     cfg_o
);

  tdds_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tdds_pkg::CFG_ENABLED_MASK:    cfg_d.enabled_mask    = cfg_data_i[7:0];
        tdds_pkg::CFG_FACTOR_TABLE:    cfg_d.factor_table    = cfg_data_i;
        tdds_pkg::CFG_TILT_THRESHOLD:  cfg_d.tilt_threshold  = cfg_data_i[14:0];
        tdds_pkg::CFG_YAW_THRESHOLD:   cfg_d.yaw_threshold   = cfg_data_i[14:0];
        tdds_pkg::CFG_STILL_THRESHOLD: cfg_d.still_threshold = cfg_data_i[31:0];
        tdds_pkg::CFG_SETTLE_TIME:     cfg_d.settle_time     = cfg_data_i[15:0];
        tdds_pkg::CFG_PULSE_TIME:      cfg_d.pulse_time      = cfg_data_i[15:0];
        tdds_pkg::CFG_PULSE_OFFSET:    cfg_d.pulse_offset    = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled_mask    <= 8'd255;
      cfg_q.factor_table    <= 48'd0;
      cfg_q.tilt_threshold  <= 15'd1638;
      cfg_q.yaw_threshold   <= 15'd2048;
      cfg_q.still_threshold <= 32'd167772;
      cfg_q.settle_time     <= 16'd500;
      cfg_q.pulse_time      <= 16'd500;
      cfg_q.pulse_offset    <= 9'd300;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### src/tdds_pre.sv
// ---------------------------------------------------------------------------
// tdds_pre
// squares the gyro rates and classes each axis, then registers the tick
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tdds_pre (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tdds_pkg::cfg_t cfg_i,
  input  wire logic           up_valid_i,
  output logic                up_ready_o,
  input  wire tdds_pkg::in_t  up_data_i,
  output logic                dn_valid_o,
  input  wire logic           dn_ready_i,
  output tdds_pkg::pre_t      dn_data_o
);

  logic           b_valid_q, b_valid_d;
  tdds_pkg::pre_t b_data_q, b_data_d;

  logic signed [31:0] sq_x, sq_y, sq_z;

  function automatic logic [1:0] classify(input logic signed [15:0] g,
                                          input logic [14:0] thr);
    logic signed [16:0] g_ext;
    logic signed [16:0] t_pos;
    logic signed [16:0] t_neg;
    logic [1:0]         s;
    g_ext = {g[15], g};
    t_pos = {2'b00, thr};
    t_neg = -t_pos;
    if (g_ext > t_pos) begin
      s = tdds_pkg::SGN_PLUS;
    end else if (g_ext < t_neg) begin
      s = tdds_pkg::SGN_MINUS;
    end else begin
      s = tdds_pkg::SGN_ZERO;
    end
    return s;
  endfunction

  assign up_ready_o = !b_valid_q || dn_ready_i;

  // each square is at most 2^30, so the sum of three fits 32 bits
  assign sq_x = up_data_i.gyro_x * up_data_i.gyro_x;
  assign sq_y = up_data_i.gyro_y * up_data_i.gyro_y;
  assign sq_z = up_data_i.gyro_z * up_data_i.gyro_z;

  always_comb begin
    b_data_d.armed          = up_data_i.armed;
    b_data_d.now_ms         = up_data_i.now_ms;
    b_data_d.pulse_accepted = up_data_i.pulse_accepted;
    b_data_d.sq_sum         = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
    b_data_d.sgn_x          = classify(up_data_i.gyro_x, cfg_i.tilt_threshold);
    b_data_d.sgn_y          = classify(up_data_i.gyro_y, cfg_i.tilt_threshold);
    b_data_d.sgn_z          = classify(up_data_i.gyro_z, cfg_i.yaw_threshold);
  end

  assign b_valid_d = up_ready_o ? up_valid_i : b_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      b_data_q <= b_data_d;
    end
  end

  assign dn_valid_o = b_valid_q;
  assign dn_data_o  = b_data_q;

  `ASSERT_ON(a_pre_hold, b_valid_q && !dn_ready_i |=> b_valid_q, "pre stage lost a tick")

endmodule

`default_nettype wire

### src/tdds_seq.sv
// ---------------------------------------------------------------------------
// tdds_seq
// phase sequencer state and the registered result of each tick
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tdds_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tdds_pkg::cfg_t cfg_i,
  input  wire logic           up_valid_i,
  output logic                up_ready_o,
  input  wire tdds_pkg::pre_t up_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tdds_pkg::out_t      out_data_o
);

  tdds_pkg::phase_e                  phase_q, phase_d;
  logic [tdds_pkg::MOTOR_W-1:0]      mut_q, mut_d;
  logic                              down_q, down_d;
  logic [31:0]                       still_q, still_d;
  logic [31:0]                       pstart_q, pstart_d;

  logic           o_valid_q, o_valid_d;
  tdds_pkg::out_t res_q, res_d;
  logic           step;

  logic [tdds_pkg::MOTOR_W-1:0] mut_nxt;
  logic                         nxt_enabled;
  logic                         mut_in_table;
  logic [8:0]                   off;
  logic [1:0]                   s_x, s_y, s_z;
  logic [1:0]                   c_x, c_y, c_z;
  logic                         same, inverse;
  logic [31:0]                  settle_el, pulse_el;

  function automatic logic [1:0] fac_code(input logic [47:0] tbl,
                                          input logic [tdds_pkg::SLOT_W-1:0] m,
                                          input int unsigned a);
    return tbl[6*m + 2*a +: 2];
  endfunction

  assign up_ready_o = !o_valid_q || !out_stall_i;
  assign step       = up_valid_i && up_ready_o;

  assign mut_nxt      = mut_q + tdds_pkg::MOTOR_W'(1);
  assign nxt_enabled  = (mut_nxt < tdds_pkg::MOTOR_END) &&
                        cfg_i.enabled_mask[mut_nxt[tdds_pkg::SLOT_W-1:0]];
  assign mut_in_table = mut_q < tdds_pkg::MOTOR_END;

  assign off = (cfg_i.pulse_offset > tdds_pkg::MAX_OFFSET) ? tdds_pkg::MAX_OFFSET
                                                           : cfg_i.pulse_offset;

  // observed signs scaled by the pulse direction
  assign s_x = down_q ? tdds_pkg::sgn_neg(up_data_i.sgn_x) : up_data_i.sgn_x;
  assign s_y = down_q ? tdds_pkg::sgn_neg(up_data_i.sgn_y) : up_data_i.sgn_y;
  assign s_z = down_q ? tdds_pkg::sgn_neg(up_data_i.sgn_z) : up_data_i.sgn_z;

  // motors outside the table get the never-matching code
  always_comb begin
    c_x = tdds_pkg::SGN_NEVER;
    c_y = tdds_pkg::SGN_NEVER;
    c_z = tdds_pkg::SGN_NEVER;
    if (mut_in_table) begin
      c_x = fac_code(cfg_i.factor_table, mut_q[tdds_pkg::SLOT_W-1:0], 0);
      c_y = fac_code(cfg_i.factor_table, mut_q[tdds_pkg::SLOT_W-1:0], 1);
      c_z = fac_code(cfg_i.factor_table, mut_q[tdds_pkg::SLOT_W-1:0], 2);
    end
  end

  assign same    = (c_x == s_x) && (c_y == s_y) && (c_z == s_z);
  assign inverse = (c_x == tdds_pkg::sgn_neg(s_x)) && (c_y == tdds_pkg::sgn_neg(s_y)) &&
                   (c_z == tdds_pkg::sgn_neg(s_z));

  assign settle_el = up_data_i.now_ms - still_q;
  assign pulse_el  = up_data_i.now_ms - pstart_q;

  always_comb begin
    phase_d  = phase_q;
    mut_d    = mut_q;
    down_d   = down_q;
    still_d  = still_q;
    pstart_d = pstart_q;

    res_d                   = '0;
    res_d.pwm_command       = tdds_pkg::NEUTRAL_PWM;
    res_d.event_res         = tdds_pkg::EV_NONE;

    if (!up_data_i.armed) begin
      res_d.drive_all_neutral = 1'b1;
      phase_d                 = tdds_pkg::PH_STANDBY;
    end else begin
      unique case (phase_q)
        tdds_pkg::PH_STANDBY: begin
          down_d  = 1'b0;
          mut_d   = '0;
          still_d = up_data_i.now_ms;
          phase_d = tdds_pkg::PH_SETTLING;
        end
        tdds_pkg::PH_SETTLING: begin
          res_d.drive_all_neutral = 1'b1;
          if (up_data_i.sq_sum > cfg_i.still_threshold) begin
            still_d = up_data_i.now_ms;
          end else if (settle_el > {16'd0, cfg_i.settle_time}) begin
            phase_d  = tdds_pkg::PH_THRUSTING;
            pstart_d = up_data_i.now_ms;
          end
        end
        tdds_pkg::PH_THRUSTING: begin
          if (pulse_el < {16'd0, cfg_i.pulse_time}) begin
            res_d.drive_one   = 1'b1;
            res_d.drive_motor = mut_q;
            res_d.pwm_command = down_q ? tdds_pkg::NEUTRAL_PWM - {2'b00, off}
                                       : tdds_pkg::NEUTRAL_PWM + {2'b00, off};
            if (!up_data_i.pulse_accepted) begin
              phase_d = tdds_pkg::PH_DONE;
            end
          end else begin
            phase_d = tdds_pkg::PH_DETECTING;
          end
        end
        tdds_pkg::PH_DETECTING: begin
          res_d.event_motor = mut_q;
          if (!same && !inverse) begin
            if (down_q) begin
              res_d.event_res = tdds_pkg::EV_FAILED;
              phase_d         = tdds_pkg::PH_DONE;
            end else begin
              res_d.event_res = tdds_pkg::EV_RETRY;
              down_d          = 1'b1;
              phase_d         = tdds_pkg::PH_SETTLING;
            end
          end else begin
            res_d.event_res = same ? tdds_pkg::EV_OK : tdds_pkg::EV_REVERSED;
            phase_d         = tdds_pkg::PH_SETTLING;
            mut_d           = mut_nxt;
            down_d          = 1'b0;
            if (!nxt_enabled) begin
              phase_d = tdds_pkg::PH_DONE;
              if (same) begin
                res_d.event_res = tdds_pkg::EV_COMPLETE;
              end
            end
          end
        end
        tdds_pkg::PH_DONE: begin
          res_d.finish_request = 1'b1;
        end
        default: begin
          phase_d = tdds_pkg::PH_STANDBY;
        end
      endcase
    end

    res_d.phase = phase_d;
  end

  assign o_valid_d = up_ready_o ? up_valid_i : o_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tdds_pkg::PH_STANDBY;
      mut_q     <= '0;
      down_q    <= 1'b0;
      still_q   <= 32'd0;
      pstart_q  <= 32'd0;
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      if (step) begin
        phase_q  <= phase_d;
        mut_q    <= mut_d;
        down_q   <= down_d;
        still_q  <= still_d;
        pstart_q <= pstart_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = res_q;

  `ASSERT_NEVER(a_drive_excl,
                o_valid_q && res_q.drive_one && res_q.drive_all_neutral,
                "pulse and neutral together")
  `ASSERT_ON(a_drive_phase,
             o_valid_q && res_q.drive_one |-> res_q.phase == tdds_pkg::PH_THRUSTING ||
                                             res_q.phase == tdds_pkg::PH_DONE,
             "pulse outside thrusting")
  `ASSERT_ON(a_finish_done,
             o_valid_q && res_q.finish_request |-> res_q.phase == tdds_pkg::PH_DONE,
             "finish outside done")

endmodule

`default_nettype wire

### src/thruster_direction_detect_sequencer.sv
// ---------------------------------------------------------------------------
// thruster_direction_detect_sequencer
// tests each thruster in turn for wiring direction from gyro response
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o   | one control tick (in_t)
//   out     | output    | out_valid_o / out_stall_i | one tick result (out_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | register index and data
//
// one tick accepted per cycle while out_stall_i is low; each tick passes through
// input register, square and classify register, sequencer result register
// the sequencer state is updated in the same cycle that loads the result
// register, so consecutive ticks need no gap
// reset puts the sequencer in standby and the config registers at defaults
// out_stall_i holds each full stage and ripples back to in_stall_o through
// the stage ready terms; an empty stage keeps taking beats
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module thruster_direction_detect_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // tick input
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tdds_pkg::in_t in_data_i,
  // result output
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tdds_pkg::out_t     out_data_o,
  // configuration writes
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [47:0]   cfg_data_i
);

  tdds_pkg::cfg_t cfg;

  // input register stage
  logic          a_valid_q, a_valid_d;
  tdds_pkg::in_t a_data_q;
  logic          a_ready;

  // pre stage to sequencer
  logic           pre_ready;
  logic           b_valid;
  tdds_pkg::pre_t b_data;
  logic           seq_ready;

  tdds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // stage takes a beat when empty or when its contents move on
  assign a_ready    = !a_valid_q || pre_ready;
  assign in_stall_o = !a_ready;
  assign a_valid_d  = a_ready ? in_valid_i : a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_data_q <= in_data_i;
    end
  end

  // gyro magnitude and axis sign classes
  tdds_pre u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (a_valid_q),
    .up_ready_o (pre_ready),
    .up_data_i  (a_data_q),
    .dn_valid_o (b_valid),
    .dn_ready_i (seq_ready),
    .dn_data_o  (b_data)
  );

  // phase sequencer with the result register
  tdds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .up_valid_i  (b_valid),
    .up_ready_o  (seq_ready),
    .up_data_i   (b_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_ON(a_in_hold, a_valid_q && !pre_ready |=> a_valid_q, "input stage lost a tick")

endmodule

`default_nettype wire
